@@ rtl/mbrtu_pkg.sv @@
package mbrtu_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0] BROADCAST_ADDR = 8'h00;
   localparam logic [7:0] STATION_RESET = 8'h01;

   typedef enum logic [1:0] {
      KIND_RX_BYTE = 2'd0,
      KIND_GAP = 2'd1,
      KIND_TX_BYTE = 2'd2,
      KIND_UNUSED = 2'd3
   } in_kind_type;

   typedef enum logic [1:0] {
      OUT_RX_BYTE = 2'd0,
      OUT_VERDICT = 2'd1,
      OUT_TX_BYTE = 2'd2,
      OUT_TX_REJECT = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      STATUS_NO_FRAME = 2'd0,
      STATUS_CRC_GOOD = 2'd1,
      STATUS_CRC_ERROR = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   // work records passed from front to back
   typedef enum logic [2:0] {
      ACT_RX_BYTE,
      ACT_VERDICT,
      ACT_TX_BYTE,
      ACT_TX_FINAL,
      ACT_TX_REJECT
   } act_op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic tx_final;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [1:0] frame_status;
      logic [8:0] frame_length;
      logic [15:0] crc_error_total;
      logic last;
   } rsp_type;

   typedef struct packed {
      act_op_type op;
      logic [7:0] data_byte;
      status_type status;
      logic [8:0] length;
      logic [15:0] err_total;
      logic [15:0] crc;
   } act_type;

   // one byte through the reflected crc-16, bit by bit
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/mbrtu_front.sv @@
module mbrtu_front
   import mbrtu_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_push,
   input req_type req_item,
   output logic req_full,
   input logic csr_valid,
   input logic [7:0] csr_data,
   input logic q_full,
   output logic q_push,
   output act_type q_item
);

   logic [7:0] station_ff;
   logic [15:0] crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic match_ff, match_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] prev2_ff, prev2_in;
   logic tx_allowed_ff, tx_allowed_in;
   logic rx_enabled_ff, rx_enabled_in;
   logic tx_active_ff, tx_active_in;
   logic [15:0] err_ff, err_in;

   logic accept;
   logic addr_hit;
   logic [15:0] crc_base;
   logic [15:0] crc_tx;

   assign req_full = q_full;
   assign accept = req_push && !q_full;
   assign addr_hit = (req_item.data_byte == BROADCAST_ADDR) ||
                     (req_item.data_byte == station_ff);
   assign crc_base = tx_active_ff ? crc_ff : CRC_INIT;
   assign crc_tx = crc_feed(crc_base, req_item.data_byte);

   always_comb begin
      crc_in = crc_ff;
      count_in = count_ff;
      match_in = match_ff;
      prev_in = prev_ff;
      prev2_in = prev2_ff;
      tx_allowed_in = tx_allowed_ff;
      rx_enabled_in = rx_enabled_ff;
      tx_active_in = tx_active_ff;
      err_in = err_ff;
      q_push = 1'b0;
      q_item.op = ACT_RX_BYTE;
      q_item.data_byte = req_item.data_byte;
      q_item.status = STATUS_NO_FRAME;
      q_item.length = 9'd0;
      q_item.err_total = err_ff;
      q_item.crc = crc_tx;
      if (accept) begin
         case (req_item.kind)
            KIND_RX_BYTE: begin
               if (rx_enabled_ff) begin
                  tx_allowed_in = 1'b0;
                  if (count_ff == '0) begin
                     match_in = addr_hit;
                     if (addr_hit) begin
                        crc_in = CRC_INIT;
                     end else begin
                        count_in = COUNT_W'(1);
                     end
                  end
                  if ((count_ff == '0) ? addr_hit : match_ff) begin
                     if (count_ff > COUNT_W'(1)) begin
                        crc_in = crc_feed(crc_ff, prev2_ff);
                     end
                     if (count_ff < COUNT_W'(MAX_FRAME_BYTES)) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                     prev2_in = prev_ff;
                     prev_in = req_item.data_byte;
                     q_push = 1'b1;
                     q_item.op = ACT_RX_BYTE;
                  end
               end
            end
            KIND_GAP: begin
               q_item.op = ACT_VERDICT;
               q_item.length = 9'(count_ff);
               if (count_ff > COUNT_W'(2)) begin
                  if ({prev_ff, prev2_ff} == crc_ff) begin
                     q_item.status = STATUS_CRC_GOOD;
                  end else begin
                     q_item.status = STATUS_CRC_ERROR;
                     err_in = err_ff + 16'd1;
                  end
               end
               q_item.err_total = err_in;
               count_in = '0;
               tx_allowed_in = 1'b1;
               rx_enabled_in = 1'b1;
               tx_active_in = 1'b0;
               q_push = 1'b1;
            end
            KIND_TX_BYTE: begin
               q_push = 1'b1;
               if (!tx_active_ff && !tx_allowed_ff) begin
                  q_item.op = ACT_TX_REJECT;
               end else begin
                  tx_allowed_in = 1'b0;
                  rx_enabled_in = 1'b0;
                  crc_in = crc_tx;
                  tx_active_in = !req_item.tx_final;
                  q_item.op = req_item.tx_final ? ACT_TX_FINAL : ACT_TX_BYTE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
         crc_ff <= CRC_INIT;
         count_ff <= '0;
         match_ff <= 1'b0;
         prev_ff <= 8'h00;
         prev2_ff <= 8'h00;
         tx_allowed_ff <= 1'b0;
         rx_enabled_ff <= 1'b0;
         tx_active_ff <= 1'b0;
         err_ff <= 16'd0;
      end else begin
         if (csr_valid) begin
            station_ff <= csr_data;
         end
         crc_ff <= crc_in;
         count_ff <= count_in;
         match_ff <= match_in;
         prev_ff <= prev_in;
         prev2_ff <= prev2_in;
         tx_allowed_ff <= tx_allowed_in;
         rx_enabled_ff <= rx_enabled_in;
         tx_active_ff <= tx_active_in;
         err_ff <= err_in;
      end
   end

endmodule

@@ rtl/mbrtu_queue.sv @@
module mbrtu_queue
   import mbrtu_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input act_type push_item,
   output logic full,
   input logic pop,
   output logic empty,
   output act_type head
);

   act_type slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_AW:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head = slots_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = do_push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

@@ rtl/mbrtu_back.sv @@
module mbrtu_back
   import mbrtu_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic q_empty,
   input act_type q_head,
   output logic q_pop,
   output logic rsp_empty,
   input logic rsp_pop,
   output rsp_type rsp_item
);

   localparam logic [1:0] SUB_CRC_HIGH = 2'd2;

   logic valid_ff, valid_in;
   logic [1:0] sub_ff, sub_in;
   rsp_type out_ff, out_in;
   logic take;
   logic last_sub;

   assign take = !q_empty && (!valid_ff || rsp_pop);
   assign last_sub = (q_head.op != ACT_TX_FINAL) || (sub_ff == SUB_CRC_HIGH);
   assign q_pop = take && last_sub;
   assign rsp_empty = !valid_ff;
   assign rsp_item = out_ff;

   always_comb begin
      out_in.out_kind = OUT_RX_BYTE;
      out_in.out_byte = q_head.data_byte;
      out_in.frame_status = STATUS_NO_FRAME;
      out_in.frame_length = 9'd0;
      out_in.crc_error_total = q_head.err_total;
      out_in.last = last_sub;
      case (q_head.op)
         ACT_RX_BYTE: begin
            out_in.out_kind = OUT_RX_BYTE;
         end
         ACT_VERDICT: begin
            out_in.out_kind = OUT_VERDICT;
            out_in.out_byte = 8'h00;
            out_in.frame_status = q_head.status;
            out_in.frame_length = q_head.length;
         end
         ACT_TX_BYTE: begin
            out_in.out_kind = OUT_TX_BYTE;
         end
         ACT_TX_FINAL: begin
            // message byte, then crc low, then crc high
            out_in.out_kind = OUT_TX_BYTE;
            if (sub_ff == 2'd1) begin
               out_in.out_byte = q_head.crc[7:0];
            end else if (sub_ff == SUB_CRC_HIGH) begin
               out_in.out_byte = q_head.crc[15:8];
            end
         end
         ACT_TX_REJECT: begin
            out_in.out_kind = OUT_TX_REJECT;
            out_in.out_byte = 8'h00;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sub_in = sub_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
         sub_in = last_sub ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
   end

endmodule

@@ rtl/modbus_rtu_frame_engine_unit.sv @@
// modbus rtu slave framer with crc-16 (poly 0xa001, init 0xffff). push items
// of kind received byte, silence gap or transmit byte; pop results in order.
// a received frame is taken when its first byte is 0 or the station address;
// its bytes come back as rx results and the gap yields one verdict with
// status, length and the wrapping crc error count. after a gap a message may
// be sent: each transmit byte comes back as a line byte and the byte marked
// tx_final is followed by crc low and crc high. reception stays off from the
// start of a transmission until the next gap. the front takes one item every
// cycle while the queue is not full and does all frame bookkeeping, including
// a full byte of crc, in that cycle; items are registered in a 4-entry work
// queue, and the back hands out one result per cycle from its output reg
// while results are popped; a final transmit byte yields three results.
// station_address resets to 1 and is written through the csr channel, which
// is always ready; write it only while no transfer is in flight.
module modbus_rtu_frame_engine_unit
   import mbrtu_pkg::*;
(
   input logic clock,
   input logic reset,
   // input item channel
   input logic req_push,
   output logic req_full,
   input req_type req_item,
   // result channel
   output logic rsp_empty,
   input logic rsp_pop,
   output rsp_type rsp_item,
   // station address register
   input logic csr_valid,
   output logic csr_ready,
   input logic [7:0] csr_data
);

   logic q_push, q_full, q_pop, q_empty;
   act_type q_item, q_head;

   assign csr_ready = 1'b1;

   // classify the item and update frame state
   mbrtu_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_item(req_item),
      .req_full(req_full),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_item(q_item)
   );

   // work records waiting for the back
   mbrtu_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(q_item),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .head(q_head)
   );

   // expand records into result transfers
   mbrtu_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

endmodule

@@ rtl/mbrtu_checker.sv @@
module mbrtu_checker
   import mbrtu_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_empty,
   input logic rsp_pop,
   input rsp_type rsp_item
);

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_item))
      else $error("waiting result changed");

   // verdict fields only in verdicts
   a_verdict_only: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_item.out_kind != OUT_VERDICT |->
         rsp_item.frame_status == STATUS_NO_FRAME && rsp_item.frame_length == 9'd0)
      else $error("status or length outside a verdict");

   // a rejection and a verdict are single results
   a_single: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_item.out_kind == OUT_TX_REJECT ||
                     rsp_item.out_kind == OUT_VERDICT) |->
         rsp_item.last && rsp_item.out_byte == 8'h00)
      else $error("malformed verdict or rejection");

   // the error count never moves between results of one item
   a_err_steady: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_item.last |=>
         !rsp_empty && $stable(rsp_item.crc_error_total))
      else $error("error count changed within one item");

endmodule

bind modbus_rtu_frame_engine_unit mbrtu_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_item(rsp_item)
);
